@@ hw/rtl/rcws_pkg.sv @@
package rcws_pkg;

   // Default configuration of the core
   localparam int MAX_LEN_DEF     = 16;
   localparam int PRICE_WIDTH_DEF = 16;

   // Fixed widths of the channel payloads
   localparam int OP_W       = 1;
   localparam int IDX_W      = 5;
   localparam int PRICE_IN_W = 16;
   localparam int ROD_W      = 5;
   localparam int KIND_W     = 1;
   localparam int RES_W      = 20;

   localparam logic [RES_W-1:0] VALUE_MAX = {RES_W{1'b1}};

   // Operation codes on the request channel
   localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
   localparam logic [OP_W-1:0] OP_SOLVE = 1'b1;

   // Kinds of result on the response channel
   localparam logic [KIND_W-1:0] KIND_REVENUE = 1'b0;
   localparam logic [KIND_W-1:0] KIND_PIECE   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_TAIL,
      ST_REV,
      ST_WALK_RD,
      ST_WALK_EMIT
   } state_type;

endpackage

@@ hw/rtl/rcws_if.sv @@
interface rcws_req_if;
   logic                            valid;
   logic                            ready;
   logic [rcws_pkg::OP_W-1:0]       operation;
   logic [rcws_pkg::IDX_W-1:0]      piece_index;
   logic [rcws_pkg::PRICE_IN_W-1:0] piece_price;
   logic [rcws_pkg::ROD_W-1:0]      rod_length;

   modport source (
      output valid, operation, piece_index, piece_price, rod_length,
      input  ready
   );
   modport sink (
      input  valid, operation, piece_index, piece_price, rod_length,
      output ready
   );
endinterface

interface rcws_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rcws_pkg::KIND_W-1:0] result_kind;
   logic [rcws_pkg::RES_W-1:0]  result_value;
   logic                        last_result;

   modport source (
      output valid, result_kind, result_value, last_result,
      input  ready
   );
   modport sink (
      input  valid, result_kind, result_value, last_result,
      output ready
   );
endinterface

@@ hw/rtl/rod_cut_with_solution_core.sv @@
// Rod cutting core. A load transaction (operation 0) writes the price of one piece length
// (1..MAX_LEN); indexes outside that range are dropped, and all prices are
// zero after reset. A solve transaction (operation 1) takes a rod length, saturated to MAX_LEN,
// fills the best-revenue and first-cut tables bottom up and then returns one revenue
// transaction followed by the cut piece lengths, smallest winning first piece on ties, with
// last_result set on the final one. Length zero returns a single revenue of 0. Revenue above
// the 20-bit result field saturates to all ones. Filling uses the single adder-comparator,
// fed by one price-table read and one best-revenue read per cycle while a length is filled,
// and each length's result is written back once its final candidate has been compared;
// the request side is not ready during a solve.
// A new transaction is taken while the last result still waits in the output register.
module rod_cut_with_solution_core #(
   parameter int MAX_LEN     = rcws_pkg::MAX_LEN_DEF,
   parameter int PRICE_WIDTH = rcws_pkg::PRICE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   rcws_req_if.sink          req_ch,
   rcws_rsp_if.source        rsp_ch
);

   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int PADDR_W = $clog2(MAX_LEN > 1 ? MAX_LEN : 2);
   localparam int REV_W   = PRICE_WIDTH + LEN_W;
   localparam int ENTRY_W = REV_W + LEN_W;
   localparam int CMP_W   = (REV_W > rcws_pkg::RES_W) ? REV_W : rcws_pkg::RES_W;

   // Sequencer state and loop counters
   rcws_pkg::state_type state_ff, state_in;
   logic [LEN_W-1:0]    n_ff, n_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    cut_ff, cut_in;
   logic [LEN_W-1:0]    rest_ff, rest_in;

   // Price table: RAM plus a valid bit per entry, so that reset reads as zero
   logic [MAX_LEN-1:0]     price_vld_ff, price_vld_in;
   logic                   price_we;
   logic [PADDR_W-1:0]     price_waddr;
   logic [PRICE_WIDTH-1:0] price_wdata;
   logic [PADDR_W-1:0]     price_raddr;
   logic [PRICE_WIDTH-1:0] price_rdata;

   // Best revenue and first cut, held together per length
   logic               dp_we;
   logic [LEN_W-1:0]   dp_waddr;
   logic [ENTRY_W-1:0] dp_wdata;
   logic [LEN_W-1:0]   dp_raddr;
   logic [ENTRY_W-1:0] dp_rdata;
   logic [REV_W-1:0]   dp_rev;
   logic [LEN_W-1:0]   dp_cut;

   // Compare stage of the shared add/compare unit
   logic             issue;
   logic             cmp_valid_ff;
   logic [LEN_W-1:0] cmp_cut_ff;
   logic             cmp_first_ff;
   logic             pv_ff;
   logic [REV_W-1:0] best_ff;
   logic [LEN_W-1:0] choice_ff;
   logic [PRICE_WIDTH-1:0] price_val;
   logic [REV_W-1:0] cand;
   logic             take;
   logic [REV_W-1:0] best_next;
   logic [LEN_W-1:0] choice_next;

   // Reconstruction
   logic [LEN_W-1:0] piece;
   logic [LEN_W-1:0] rest_left;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rcws_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [rcws_pkg::RES_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              out_free;
   logic                              emit;
   logic [rcws_pkg::KIND_W-1:0]       emit_kind;
   logic [rcws_pkg::RES_W-1:0]        emit_value;
   logic                              emit_last;
   logic [CMP_W-1:0]                  rev_wide;
   logic [rcws_pkg::RES_W-1:0]        rev_sat;

   // Request decode
   logic             req_ready;
   logic             req_fire;
   logic             load_ok;
   logic [LEN_W-1:0] n_sat;

   assign req_fire = req_ch.valid && req_ready;
   assign load_ok  = (req_ch.piece_index != '0) &&
                     (32'(req_ch.piece_index) <= 32'(MAX_LEN));
   assign n_sat    = (32'(req_ch.rod_length) > 32'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                             : LEN_W'(req_ch.rod_length);

   // Price writes come straight from an accepted load transaction
   assign price_we    = req_fire && (req_ch.operation == rcws_pkg::OP_LOAD) && load_ok;
   assign price_waddr = PADDR_W'(req_ch.piece_index - rcws_pkg::IDX_W'(1));
   assign price_wdata = PRICE_WIDTH'(req_ch.piece_price);
   assign price_raddr = PADDR_W'(cut_ff - LEN_W'(1));

   always_comb begin
      price_vld_in = price_vld_ff;
      if (price_we) begin
         price_vld_in[price_waddr] = 1'b1;
      end
   end

   rcws_ram #(
      .WIDTH (PRICE_WIDTH),
      .DEPTH (MAX_LEN)
   ) u_price_ram (
      .clock (clock),
      .we    (price_we),
      .waddr (price_waddr),
      .wdata (price_wdata),
      .raddr (price_raddr),
      .rdata (price_rdata)
   );

   rcws_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LEN + 1)
   ) u_dp_ram (
      .clock (clock),
      .we    (dp_we),
      .waddr (dp_waddr),
      .wdata (dp_wdata),
      .raddr (dp_raddr),
      .rdata (dp_rdata)
   );

   assign dp_rev = dp_rdata[ENTRY_W-1:LEN_W];
   assign dp_cut = dp_rdata[LEN_W-1:0];

   // Read best revenue of the remainder while filling, else of the length being walked
   assign dp_raddr = (state_ff == rcws_pkg::ST_FILL) ? (len_ff - cut_ff) : rest_ff;

   // Shared add/compare: price of the first piece plus best revenue of what is left.
   // Strict greater-than keeps the smallest first piece on ties.
   assign price_val   = pv_ff ? price_rdata : '0;
   assign cand        = REV_W'(price_val) + dp_rev;
   assign take        = cmp_first_ff || (cand > best_ff);
   assign best_next   = take ? cand : best_ff;
   assign choice_next = take ? cmp_cut_ff : choice_ff;

   // Walk the first-cut table; guard against a piece longer than the remainder
   assign piece     = ((dp_cut == '0) || (dp_cut > rest_ff)) ? rest_ff : dp_cut;
   assign rest_left = rest_ff - piece;

   assign rev_wide = CMP_W'(best_ff);
   assign rev_sat  = (rev_wide > CMP_W'(rcws_pkg::VALUE_MAX)) ? rcws_pkg::VALUE_MAX
                                                             : rcws_pkg::RES_W'(rev_wide);

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcws_pkg::ST_IDLE: begin
            if (req_fire && (req_ch.operation == rcws_pkg::OP_SOLVE)) begin
               state_in = (n_sat == '0) ? rcws_pkg::ST_REV : rcws_pkg::ST_FILL;
            end
         end
         rcws_pkg::ST_FILL: begin
            if (cut_ff == len_ff) begin
               state_in = rcws_pkg::ST_TAIL;
            end
         end
         rcws_pkg::ST_TAIL: begin
            state_in = (len_ff == n_ff) ? rcws_pkg::ST_REV : rcws_pkg::ST_FILL;
         end
         rcws_pkg::ST_REV: begin
            if (out_free) begin
               state_in = (n_ff == '0) ? rcws_pkg::ST_IDLE : rcws_pkg::ST_WALK_RD;
            end
         end
         rcws_pkg::ST_WALK_RD: begin
            state_in = rcws_pkg::ST_WALK_EMIT;
         end
         rcws_pkg::ST_WALK_EMIT: begin
            if (out_free) begin
               state_in = (rest_left == '0) ? rcws_pkg::ST_IDLE : rcws_pkg::ST_WALK_RD;
            end
         end
         default: begin
            state_in = rcws_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs and counter updates
   always_comb begin
      req_ready  = 1'b0;
      issue      = 1'b0;
      dp_we      = 1'b0;
      dp_waddr   = len_ff;
      dp_wdata   = {best_next, choice_next};
      emit       = 1'b0;
      emit_kind  = rcws_pkg::KIND_REVENUE;
      emit_value = rev_sat;
      emit_last  = 1'b0;
      n_in       = n_ff;
      len_in     = len_ff;
      cut_in     = cut_ff;
      rest_in    = rest_ff;
      case (state_ff)
         rcws_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire && (req_ch.operation == rcws_pkg::OP_SOLVE)) begin
               // Seed length zero: no revenue, no cut
               dp_we    = 1'b1;
               dp_waddr = '0;
               dp_wdata = '0;
               n_in     = n_sat;
               len_in   = LEN_W'(1);
               cut_in   = LEN_W'(1);
               rest_in  = n_sat;
            end
         end
         rcws_pkg::ST_FILL: begin
            issue = 1'b1;
            if (cut_ff != len_ff) begin
               cut_in = cut_ff + LEN_W'(1);
            end
         end
         rcws_pkg::ST_TAIL: begin
            // Last candidate is in the compare stage: store the winner
            dp_we  = 1'b1;
            len_in = len_ff + LEN_W'(1);
            cut_in = LEN_W'(1);
         end
         rcws_pkg::ST_REV: begin
            emit       = out_free;
            emit_kind  = rcws_pkg::KIND_REVENUE;
            emit_value = (n_ff == '0) ? '0 : rev_sat;
            emit_last  = (n_ff == '0);
         end
         rcws_pkg::ST_WALK_RD: begin
         end
         rcws_pkg::ST_WALK_EMIT: begin
            emit       = out_free;
            emit_kind  = rcws_pkg::KIND_PIECE;
            emit_value = rcws_pkg::RES_W'(piece);
            emit_last  = (rest_left == '0);
            if (out_free) begin
               rest_in = rest_left;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_value_in = emit_value;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcws_pkg::ST_IDLE;
         price_vld_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cut_ff       <= LEN_W'(1);
      end else begin
         state_ff     <= state_in;
         price_vld_ff <= price_vld_in;
         cmp_valid_ff <= issue;
         rsp_valid_ff <= rsp_valid_in;
         cut_ff       <= cut_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      len_ff       <= len_in;
      rest_ff      <= rest_in;
      cmp_cut_ff   <= cut_ff;
      cmp_first_ff <= (cut_ff == LEN_W'(1));
      pv_ff        <= price_vld_ff[price_raddr];
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (cmp_valid_ff) begin
         best_ff   <= best_next;
         choice_ff <= choice_next;
      end
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_kind  = rsp_kind_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.last_result  = rsp_last_ff;

   // The inner loop never runs past the length being solved
   a_fill_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcws_pkg::ST_FILL) |->
         (cut_ff != '0) && (cut_ff <= len_ff) && (len_ff <= n_ff))
      else $error("fill counters out of range");

   // Write-back only when the final candidate of the length is being compared
   a_tail_has_cand: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcws_pkg::ST_TAIL) |-> cmp_valid_ff && (cmp_cut_ff == len_ff))
      else $error("write-back without final candidate");

   // A walked length is always a real remainder of the rod
   a_walk_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcws_pkg::ST_WALK_EMIT) |-> (rest_ff != '0) && (rest_ff <= n_ff))
      else $error("walk remainder out of range");

   // A result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_value_ff) && rsp_valid_ff)
      else $error("pending result overwritten");

endmodule

@@ hw/rtl/rcws_ram.sv @@
module rcws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

   // Generous ceiling: roughly 170 transactions, each worst case a full-length solve
   // with 17 results each held off by a long stall and a long sender gap,
   // taken several times over.
   localparam int CYCLE_LIMIT  = 800000;
   localparam int RANDOM_ITEMS = 145;
   localparam int DRAIN_CYCLES = 200;
   localparam int N_DIRECTED   = 23;

   // One result transaction as the core presents it.
   typedef struct packed {
      logic [rcws_pkg::KIND_W-1:0] kind;
      logic [rcws_pkg::RES_W-1:0]  value;
      logic                        last;
   } cut_result_type;

   // One row of the directed stimulus. Rows with typed set carry their own expected
   // revenue and at most one piece (piece_typed of zero means no piece follows).
   typedef struct packed {
      logic [rcws_pkg::OP_W-1:0]       op;
      logic [rcws_pkg::IDX_W-1:0]      idx;
      logic [rcws_pkg::PRICE_IN_W-1:0] price;
      logic [rcws_pkg::ROD_W-1:0]      rod;
      logic                            typed;
      logic [rcws_pkg::RES_W-1:0]      rev_typed;
      logic [4:0]                      piece_typed;
   } probe_type;

   logic clock = 1'b0;
   logic reset;

   rcws_req_if req_ch ();
   rcws_rsp_if rsp_ch ();

   rod_cut_with_solution_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: its own copy of the price list, and the results still owed.
   logic [rcws_pkg::PRICE_WIDTH_DEF-1:0] price_list [1:rcws_pkg::MAX_LEN_DEF];
   cut_result_type                       cut_results_due [$];

   int failures    = 0;
   int cycle_count = 0;
   bit calm        = 1'b0;   // when set, neither side starts a new idle stretch
   int stall_left  = 0;

   // Directed rows: extremes, ignored loads, saturation of the length, ties and
   // multi-piece solutions. Only the after-reset and single-price cases are typed in.
   probe_type directed_rows [0:N_DIRECTED-1] = '{
      // solve length zero straight after reset: revenue 0, last, no pieces
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd0,  1'b1, 20'd0,     5'd0},
      // all prices zero: revenue 0, one piece of length 1
      '{rcws_pkg::OP_SOLVE, 5'd1,  16'h0000, 5'd1,  1'b1, 20'd0,     5'd1},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd16, 1'b0, 20'd0,     5'd0},
      // loads outside 1..MAX_LEN must leave the prices untouched
      '{rcws_pkg::OP_LOAD,  5'd0,  16'hFFFF, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd17, 16'hFFFF, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd31, 16'hFFFF, 5'd31, 1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd2,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd1,  16'hFFFF, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd1,  1'b1, 20'd65535, 5'd1},
      // largest revenue: sixteen pieces at the top price
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd16, 1'b0, 20'd0,     5'd0},
      // lengths above MAX_LEN saturate
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd31, 1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd17, 1'b0, 20'd0,     5'd0},
      // tie at length 2: 1+1 against 2, the smaller first piece wins
      '{rcws_pkg::OP_LOAD,  5'd1,  16'h0001, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd2,  16'h0002, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd2,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd3,  16'd100,  5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd7,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd16, 16'hAAAA, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd15, 16'h5555, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd16, 1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd15, 1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_LOAD,  5'd1,  16'h0000, 5'd0,  1'b0, 20'd0,     5'd0},
      '{rcws_pkg::OP_SOLVE, 5'd0,  16'h0000, 5'd3,  1'b0, 20'd0,     5'd0}
   };

   function automatic void note_result(input logic [rcws_pkg::KIND_W-1:0] kind,
                                       input logic [rcws_pkg::RES_W-1:0] value,
                                       input logic last);
      cut_result_type r;
      r.kind  = kind;
      r.value = value;
      r.last  = last;
      cut_results_due.push_back(r);
   endfunction

   // Fill best revenue and first cut bottom up, then queue the revenue and the pieces
   // in reconstruction order.
   function automatic void plan_cuts(input logic [rcws_pkg::ROD_W-1:0] rod);
      logic [rcws_pkg::RES_W:0] revenue [0:rcws_pkg::MAX_LEN_DEF];
      int                       first_piece [0:rcws_pkg::MAX_LEN_DEF];
      logic [rcws_pkg::RES_W:0] best;
      logic [rcws_pkg::RES_W:0] cand;
      int                       n;
      int                       choice;
      int                       rest;
      int                       piece;
      n = (rod > rcws_pkg::MAX_LEN_DEF) ? rcws_pkg::MAX_LEN_DEF : int'(rod);
      revenue[0]     = '0;
      first_piece[0] = 0;
      for (int len = 1; len <= n; len++) begin
         best   = price_list[1] + revenue[len-1];
         choice = 1;
         for (int c = 2; c <= len; c++) begin
            cand = price_list[c] + revenue[len-c];
            // strictly greater only: keep the smallest first piece on a tie
            if (cand > best) begin
               best   = cand;
               choice = c;
            end
         end
         revenue[len]     = best;
         first_piece[len] = choice;
      end
      note_result(rcws_pkg::KIND_REVENUE,
                  (revenue[n] > rcws_pkg::VALUE_MAX) ? rcws_pkg::VALUE_MAX
                                                     : revenue[n][rcws_pkg::RES_W-1:0],
                  n == 0);
      rest = n;
      while (rest > 0) begin
         piece = first_piece[rest];
         if (piece == 0 || piece > rest) begin
            piece = rest;
         end
         rest -= piece;
         note_result(rcws_pkg::KIND_PIECE, rcws_pkg::RES_W'(piece), rest == 0);
      end
   endfunction

   function automatic bit is_ignored(input logic [rcws_pkg::OP_W-1:0] op,
                                     input logic [rcws_pkg::IDX_W-1:0] idx);
      return op == rcws_pkg::OP_LOAD && (idx == 0 || idx > rcws_pkg::MAX_LEN_DEF);
   endfunction

   // Advance the predictor by one accepted request transaction.
   function automatic void absorb_request(input logic [rcws_pkg::OP_W-1:0] op,
                                          input logic [rcws_pkg::IDX_W-1:0] idx,
                                          input logic [rcws_pkg::PRICE_IN_W-1:0] price,
                                          input logic [rcws_pkg::ROD_W-1:0] rod);
      if (op == rcws_pkg::OP_LOAD) begin
         if (!is_ignored(op, idx)) begin
            price_list[idx] = price[rcws_pkg::PRICE_WIDTH_DEF-1:0];
         end
      end else begin
         plan_cuts(rod);
      end
   endfunction

   // Present one request at the falling edge and hold it until the core takes it.
   // Returns at the falling edge after acceptance.
   task automatic offer(input logic [rcws_pkg::OP_W-1:0] op,
                        input logic [rcws_pkg::IDX_W-1:0] idx,
                        input logic [rcws_pkg::PRICE_IN_W-1:0] price,
                        input logic [rcws_pkg::ROD_W-1:0] rod);
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.piece_index <= idx;
      req_ch.piece_price <= price;
      req_ch.rod_length  <= rod;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Sender gap: mostly none or short, now and then long; none at all while calm.
   task automatic idle_sender();
      int cycles;
      if (calm) begin
         cycles = 0;
      end else if ($urandom_range(0, 9) < 6) begin
         cycles = 0;
      end else if ($urandom_range(0, 3) != 0) begin
         cycles = $urandom_range(1, 3);
      end else begin
         cycles = $urandom_range(10, 40);
      end
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Receiver: stall at random; one stall in ten runs for a long stretch.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest one owed, field by field.
   always @(posedge clock) begin : result_check
      cut_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cut_results_due.size() == 0) begin
            failures++;
            $display("%0t: result with none owed: kind %0d value %0d last %0d", $time,
                     rsp_ch.result_kind, rsp_ch.result_value, rsp_ch.last_result);
         end else begin
            want = cut_results_due.pop_front();
            if (rsp_ch.result_kind !== want.kind) begin
               failures++;
               $display("%0t: result_kind expected %0d actual %0d", $time,
                        want.kind, rsp_ch.result_kind);
            end
            if (rsp_ch.result_value !== want.value) begin
               failures++;
               $display("%0t: result_value expected %0d actual %0d", $time,
                        want.value, rsp_ch.result_value);
            end
            if (rsp_ch.last_result !== want.last) begin
               failures++;
               $display("%0t: last_result expected %0d actual %0d", $time,
                        want.last, rsp_ch.last_result);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      probe_type                       row;
      logic [rcws_pkg::OP_W-1:0]       op;
      logic [rcws_pkg::IDX_W-1:0]      idx;
      logic [rcws_pkg::PRICE_IN_W-1:0] price;
      logic [rcws_pkg::ROD_W-1:0]      rod;
      int                              counted;
      int                              block_left;

      // Known values on every input from time zero, with reset held at the start.
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = rcws_pkg::OP_LOAD;
      req_ch.piece_index = '0;
      req_ch.piece_price = '0;
      req_ch.rod_length  = '0;
      rsp_ch.ready       = 1'b0;
      for (int i = 1; i <= rcws_pkg::MAX_LEN_DEF; i++) begin
         price_list[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: typed rows push their own expectation, the rest go through
      // the predictor.
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         offer(row.op, row.idx, row.price, row.rod);
         if (row.typed) begin
            note_result(rcws_pkg::KIND_REVENUE, row.rev_typed, row.piece_typed == 0);
            if (row.piece_typed != 0) begin
               note_result(rcws_pkg::KIND_PIECE, rcws_pkg::RES_W'(row.piece_typed), 1'b1);
            end
         end else begin
            absorb_request(row.op, row.idx, row.price, row.rod);
         end
         idle_sender();
      end

      // Random part, in blocks that are either calm or stalling on both sides.
      // Loads the core drops do not count towards the total.
      counted    = 0;
      block_left = 0;
      while (counted < RANDOM_ITEMS) begin
         if (block_left == 0) begin
            calm       = ($urandom_range(0, 3) == 0);
            block_left = 30;
         end
         block_left--;
         op  = ($urandom_range(0, 99) < 45) ? rcws_pkg::OP_LOAD : rcws_pkg::OP_SOLVE;
         idx = rcws_pkg::IDX_W'($urandom_range(1, rcws_pkg::MAX_LEN_DEF));
         if ($urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, 1) ? '0
                  : rcws_pkg::IDX_W'($urandom_range(rcws_pkg::MAX_LEN_DEF + 1, 31));
         end
         // small prices make ties common; full-range prices exercise every bit
         price = ($urandom_range(0, 3) == 0) ? rcws_pkg::PRICE_IN_W'($urandom_range(0, 7))
                                             : rcws_pkg::PRICE_IN_W'($urandom_range(0, 65535));
         rod   = ($urandom_range(0, 9) == 0)
                 ? rcws_pkg::ROD_W'($urandom_range(rcws_pkg::MAX_LEN_DEF + 1, 31))
                 : rcws_pkg::ROD_W'($urandom_range(0, rcws_pkg::MAX_LEN_DEF));
         offer(op, idx, price, rod);
         absorb_request(op, idx, price, rod);
         if (!is_ignored(op, idx)) begin
            counted++;
         end
         idle_sender();
      end

      // Drop valid, drain what is owed, then give stray results time to show.
      req_ch.valid <= 1'b0;
      calm = 1'b0;
      while (cut_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
